>>> rtl/assert_macros.svh
// Assertion helpers for the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked implication with the synchronous reset as disable
`define ASSERT_CLK(label, clk, rstn, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Clocked implication checked during reset as well
`define ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> rtl/kpv_pkg.sv
package kpv_pkg;

    localparam int DW = 32;
    localparam int FB = 16;
    localparam int PW = 2 * DW;

    localparam logic signed [DW-1:0] SMAX = {1'b0, {(DW-1){1'b1}}};
    localparam logic signed [DW-1:0] SMIN = {1'b1, {(DW-1){1'b0}}};
    localparam logic signed [DW-1:0] ONE  = DW'(64'sd1 << FB);

    localparam logic [2:0] REG_QPP = 3'd0;
    localparam logic [2:0] REG_QPV = 3'd1;
    localparam logic [2:0] REG_QVP = 3'd2;
    localparam logic [2:0] REG_QVV = 3'd3;
    localparam logic [2:0] REG_R   = 3'd4;

    localparam logic [2:0] MA_POS = 3'd0;
    localparam logic [2:0] MA_VEL = 3'd1;
    localparam logic [2:0] MA_P00 = 3'd2;
    localparam logic [2:0] MA_P01 = 3'd3;
    localparam logic [2:0] MA_P10 = 3'd4;
    localparam logic [2:0] MA_P11 = 3'd5;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_RD,
        ST_OP,
        ST_MUL,
        ST_DIV,
        ST_OUT
    } state_t;

    function automatic logic signed [DW-1:0] sat_add(
        input logic signed [DW-1:0] a, input logic signed [DW-1:0] b, input logic neg_b);
        logic signed [DW+1:0] s;
        begin
            s = neg_b ? ($signed({{2{a[DW-1]}}, a}) - $signed({{2{b[DW-1]}}, b}))
                      : ($signed({{2{a[DW-1]}}, a}) + $signed({{2{b[DW-1]}}, b}));
            if (s > $signed({{2{1'b0}}, SMAX})) sat_add = SMAX;
            else if (s < $signed({{2{1'b1}}, SMIN})) sat_add = SMIN;
            else sat_add = s[DW-1:0];
        end
    endfunction

    function automatic logic signed [DW-1:0] from_mag(
        input logic neg, input logic [PW-1:0] m);
        logic [PW-1:0] lim;
        logic [PW-1:0] v;
        begin
            lim = {{(PW-DW){1'b0}}, 1'b0, {(DW-1){1'b1}}} + {{(PW-1){1'b0}}, neg};
            v = (m > lim) ? lim : m;
            from_mag = neg ? DW'(-v) : DW'(v);
        end
    endfunction

    function automatic logic [DW-1:0] mag(input logic signed [DW-1:0] a);
        mag = a[DW-1] ? DW'(-a) : DW'(a);
    endfunction

endpackage

>>> rtl/kalman_pos_vel_filter.sv
// Two-state altitude Kalman filter (position, velocity, 2x2 covariance) in
// signed Q16.16. A beat with req_type 0 predicts over dt with the given
// acceleration, req_type 1 corrects with an altitude measurement; each input
// beat yields one output beat with position, velocity and P00. The state is
// kept in a six-word memory and is worked by a microcode sequence on one
// shared 32x32 multiplier, one saturating adder and a radix-2 divider.
// After reset the memory is loaded with its initial values before the first
// beat is taken. A predict beat runs the memory reads, seven multiplies and
// twelve adds and the write-back; an update beat runs the memory reads, two
// divisions of 48 steps each, six multiplies, eight adds and the write-back.
// The write-back ends only once the output register is free. One item is in
// work at a time; the next beat is taken once the result has been moved to
// the output register.
module kalman_pos_vel_filter
    import kpv_pkg::*;
(
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          cfg_valid,
    output logic          cfg_ready,
    input  logic [2:0]    cfg_index,
    input  logic [31:0]   cfg_data,
    input  logic          s_tvalid,
    output logic          s_tready,
    input  logic          s_tuser,     // req_type
    input  logic [87:0]   s_tdata,     // dt[15:0], accel[47:16], measurement[79:48]
    output logic          m_tvalid,
    input  logic          m_tready,
    output logic [95:0]   m_tdata      // pos_est[31:0], vel_est[63:32], pos_variance[95:64]
);

    // Microcode: each op reads A and B operands from temporaries, applies
    // fn, writes a temporary. Temporaries 0..5 mirror the memory words.
    typedef enum logic [2:0] {
        F_MUL, F_ADD, F_SUB, F_HALF, F_DIV
    } fn_t;

    typedef struct packed {
        fn_t        fn;
        logic [3:0] a;
        logic [3:0] b;
        logic [3:0] d;
    } uop_t;

    // temp indexes
    localparam logic [3:0] T_POS = 4'd0, T_VEL = 4'd1, T_P00 = 4'd2, T_P01 = 4'd3;
    localparam logic [3:0] T_P10 = 4'd4, T_P11 = 4'd5, T_DT = 4'd6, T_IN = 4'd7;
    localparam logic [3:0] T_X = 4'd8, T_Y = 4'd9, T_Z = 4'd10, T_W = 4'd11;
    localparam logic [3:0] T_QPP = 4'd12, T_QPV = 4'd13, T_QVP = 4'd14, T_QVV = 4'd15;
    // T_QPP reused for R on update

    localparam int NPRED = 19;
    localparam int NUPD = 16;

    function automatic uop_t uop(input logic upd, input logic [4:0] k);
        uop_t u;
        begin
            u = '{F_ADD, 4'd0, 4'd0, 4'd0};
            if (!upd) begin
                unique case (k)
                    5'd0:  u = '{F_MUL, T_IN,  T_DT,  T_X};   // adt
                    5'd1:  u = '{F_MUL, T_X,   T_DT,  T_Y};
                    5'd2:  u = '{F_HALF, T_Y,  T_Y,   T_Y};   // half
                    5'd3:  u = '{F_MUL, T_VEL, T_DT,  T_Z};
                    5'd4:  u = '{F_ADD, T_POS, T_Z,   T_POS};
                    5'd5:  u = '{F_ADD, T_POS, T_Y,   T_POS};
                    5'd6:  u = '{F_ADD, T_VEL, T_X,   T_VEL};
                    5'd7:  u = '{F_MUL, T_DT,  T_P10, T_Z};
                    5'd8:  u = '{F_ADD, T_P00, T_Z,   T_Z};   // a00
                    5'd9:  u = '{F_MUL, T_DT,  T_P11, T_W};
                    5'd10: u = '{F_ADD, T_P01, T_W,   T_W};   // a01
                    5'd11: u = '{F_MUL, T_W,   T_DT,  T_X};
                    5'd12: u = '{F_ADD, T_Z,   T_X,   T_P00};
                    5'd13: u = '{F_ADD, T_P00, T_QPP, T_P00};
                    5'd14: u = '{F_ADD, T_W,   T_QPV, T_P01};
                    5'd15: u = '{F_MUL, T_P11, T_DT,  T_X};
                    5'd16: u = '{F_ADD, T_P10, T_X,   T_P10};
                    5'd17: u = '{F_ADD, T_P10, T_QVP, T_P10};
                    default: u = '{F_ADD, T_P11, T_QVV, T_P11};
                endcase
            end else begin
                unique case (k)
                    5'd0:  u = '{F_ADD, T_P00, T_QPP, T_DT};  // s
                    5'd1:  u = '{F_DIV, T_P00, T_DT,  T_X};   // k0
                    5'd2:  u = '{F_DIV, T_P10, T_DT,  T_Y};   // k1
                    5'd3:  u = '{F_SUB, T_IN,  T_POS, T_Z};   // y
                    5'd4:  u = '{F_MUL, T_X,   T_Z,   T_W};
                    5'd5:  u = '{F_ADD, T_POS, T_W,   T_POS};
                    5'd6:  u = '{F_MUL, T_Y,   T_Z,   T_W};
                    5'd7:  u = '{F_ADD, T_VEL, T_W,   T_VEL};
                    5'd8:  u = '{F_MUL, T_Y,   T_P01, T_W};
                    5'd9:  u = '{F_SUB, T_P11, T_W,   T_P11};
                    5'd10: u = '{F_MUL, T_Y,   T_P00, T_W};
                    5'd11: u = '{F_SUB, T_P10, T_W,   T_P10};
                    5'd12: u = '{F_MUL, T_X,   T_P01, T_W};
                    5'd13: u = '{F_SUB, T_P01, T_W,   T_P01};
                    5'd14: u = '{F_MUL, T_X,   T_P00, T_W};
                    default: u = '{F_SUB, T_P00, T_W,  T_P00};
                endcase
            end
            uop = u;
        end
    endfunction

    logic [30:0]          qpp_reg, qvv_reg, r_reg;
    logic signed [DW-1:0] qpv_reg, qvp_reg;

    logic signed [DW-1:0] mem [0:5];
    logic                 init_reg;
    logic [2:0]           mad_reg, mad_next;
    logic signed [DW-1:0] mrd_reg;

    logic signed [DW-1:0] t_reg [0:15];
    logic signed [DW-1:0] t_wval;
    logic [3:0]           t_wadr;
    logic                 t_we;

    state_t     st_reg, st_next;
    logic       upd_reg;
    logic [4:0] k_reg, k_next;
    logic [4:0] kmax;
    uop_t       u;

    logic [PW-1:0]        prod_reg;
    logic                 pneg_reg;
    logic signed [DW-1:0] mulres;

    logic                 div_start, div_done;
    logic signed [DW-1:0] div_q;

    logic [95:0] out_reg;
    logic        ov_reg;

    assign cfg_ready = 1'b1;
    assign s_tready = (st_reg == ST_IDLE) && !init_reg;
    assign m_tvalid = ov_reg;
    assign m_tdata = out_reg;
    assign kmax = upd_reg ? 5'(NUPD - 1) : 5'(NPRED - 1);
    assign u = uop(upd_reg, k_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            qpp_reg <= '0;
            qpv_reg <= '0;
            qvp_reg <= '0;
            qvv_reg <= '0;
            r_reg <= 31'd3277;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                REG_QPP: qpp_reg <= cfg_data[30:0];
                REG_QPV: qpv_reg <= cfg_data;
                REG_QVP: qvp_reg <= cfg_data;
                REG_QVV: qvv_reg <= cfg_data[30:0];
                REG_R:   r_reg <= cfg_data[30:0];
                default: ;
            endcase
        end
    end

    // read from memory (ST_RD) walks six words, write back in ST_OUT walks six
    always_comb begin
        st_next = st_reg;
        k_next = k_reg;
        mad_next = mad_reg;
        unique case (st_reg)
            ST_IDLE: begin
                if (s_tvalid && s_tready) begin
                    st_next = ST_RD;
                    mad_next = MA_POS;
                    k_next = '0;
                end
            end
            ST_RD: begin
                if (mad_reg != MA_P11) mad_next = mad_reg + 3'd1;
                k_next = k_reg + 5'd1;
                if (k_reg == 5'd6) begin
                    st_next = ST_OP;
                    k_next = '0;
                end
            end
            ST_OP: begin
                unique case (u.fn)
                    F_MUL: st_next = ST_MUL;
                    F_DIV: st_next = ST_DIV;
                    default: begin
                        if (k_reg == kmax) begin
                            st_next = ST_OUT;
                            k_next = '0;
                        end else k_next = k_reg + 5'd1;
                    end
                endcase
            end
            ST_MUL, ST_DIV: begin
                if (st_reg == ST_MUL || div_done) begin
                    st_next = ST_OP;
                    if (k_reg == kmax) begin
                        st_next = ST_OUT;
                        k_next = '0;
                    end else k_next = k_reg + 5'd1;
                end
            end
            ST_OUT: begin
                k_next = k_reg + 5'd1;
                if (k_reg == 5'd5) begin
                    if (!ov_reg || m_tready) st_next = ST_IDLE;
                    else k_next = k_reg;
                end
            end
            default: st_next = ST_IDLE;
        endcase
    end

    always_comb begin
        t_we = 1'b0;
        t_wadr = u.d;
        t_wval = '0;
        div_start = 1'b0;
        if (st_reg == ST_RD && k_reg != 5'd0) begin
            t_we = 1'b1;
            t_wadr = 4'(k_reg - 5'd1);
            t_wval = mrd_reg;
        end else if (st_reg == ST_OP) begin
            unique case (u.fn)
                F_ADD:  begin t_we = 1'b1; t_wval = sat_add(t_reg[u.a], t_reg[u.b], 1'b0); end
                F_SUB:  begin t_we = 1'b1; t_wval = sat_add(t_reg[u.a], t_reg[u.b], 1'b1); end
                F_HALF: begin
                    t_we = 1'b1;
                    t_wval = (t_reg[u.a] + $signed({{(DW-1){1'b0}}, t_reg[u.a][DW-1]})) >>> 1;
                end
                F_DIV:  div_start = 1'b1;
                default: ;
            endcase
        end else if (st_reg == ST_MUL) begin
            t_we = 1'b1;
            t_wval = mulres;
        end else if (st_reg == ST_DIV && div_done) begin
            t_we = 1'b1;
            t_wval = div_q;
        end
    end

    assign mulres = from_mag(pneg_reg, prod_reg >> FB);

    kpv_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .num     (t_reg[u.a]),
        .den     (t_reg[u.b]),
        .done    (div_done),
        .quot    (div_q)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg <= ST_IDLE;
            k_reg <= '0;
            ov_reg <= 1'b0;
            init_reg <= 1'b1;
            mad_reg <= MA_POS;
        end else begin
            st_reg <= st_next;
            k_reg <= k_next;
            if (init_reg) begin
                mad_reg <= (mad_reg == MA_P11) ? MA_POS : mad_reg + 3'd1;
                if (mad_reg == MA_P11) init_reg <= 1'b0;
            end else begin
                mad_reg <= mad_next;
            end
            if (st_reg == ST_OUT && k_reg == 5'd5 && (!ov_reg || m_tready)) begin
                ov_reg <= 1'b1;
            end else if (ov_reg && m_tready) begin
                ov_reg <= 1'b0;
            end
        end
        // init sweep writes reset values; ST_OUT writes back temporaries
        if (!aresetn) begin
        end else if (init_reg) begin
            mem[mad_reg] <= (mad_reg == MA_P00 || mad_reg == MA_P11) ? ONE : '0;
        end else if (st_reg == ST_OUT) begin
            mem[k_reg[2:0]] <= t_reg[k_reg[3:0]];
        end
        mrd_reg <= mem[mad_reg];
        if (st_reg == ST_IDLE && s_tvalid && s_tready) begin
            t_reg[T_DT] <= $signed({{(DW-FB){1'b0}}, s_tdata[15:0]}) <<< (FB - 16);
            t_reg[T_IN] <= s_tuser ? $signed(s_tdata[79:48]) : $signed(s_tdata[47:16]);
            t_reg[T_QPP] <= s_tuser ? $signed({1'b0, r_reg}) : $signed({1'b0, qpp_reg});
            t_reg[T_QPV] <= qpv_reg;
            t_reg[T_QVP] <= qvp_reg;
            t_reg[T_QVV] <= $signed({1'b0, qvv_reg});
            upd_reg <= s_tuser;
        end else if (t_we) begin
            t_reg[t_wadr] <= t_wval;
        end
        if (st_reg == ST_OP) begin
            prod_reg <= PW'(mag(t_reg[u.a])) * PW'(mag(t_reg[u.b]));
            pneg_reg <= t_reg[u.a][DW-1] ^ t_reg[u.b][DW-1];
        end
        if (st_reg == ST_OUT && k_reg == 5'd5 && (!ov_reg || m_tready)) begin
            out_reg <= {t_reg[T_P00], t_reg[T_VEL], t_reg[T_POS]};
        end
    end

endmodule

>>> rtl/kpv_div.sv
module kpv_div
    import kpv_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 start,
    input  logic signed [DW-1:0] num,
    input  logic signed [DW-1:0] den,
    output logic                 done,
    output logic signed [DW-1:0] quot
);

    localparam int NW = DW + FB;
    localparam int CW = $clog2(NW + 1);

    logic [NW-1:0] n_reg, n_next;
    logic [NW-1:0] q_reg, q_next;
    logic [DW:0]   r_reg, r_next;
    logic [DW-1:0] d_reg, d_next;
    logic          neg_reg, neg_next;
    logic          zero_reg, zero_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic          busy_reg, busy_next;
    logic          done_reg, done_next;
    logic [DW:0]   trial;

    always_comb begin
        n_next = n_reg;
        q_next = q_reg;
        r_next = r_reg;
        d_next = d_reg;
        neg_next = neg_reg;
        zero_next = zero_reg;
        cnt_next = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        trial = {r_reg[DW-1:0], n_reg[NW-1]};
        if (start) begin
            n_next = {mag(num), {FB{1'b0}}};
            d_next = mag(den);
            neg_next = num[DW-1] ^ den[DW-1];
            zero_next = (den == '0);
            r_next = '0;
            q_next = '0;
            cnt_next = CW'(NW);
            busy_next = 1'b1;
        end else if (busy_reg) begin
            n_next = {n_reg[NW-2:0], 1'b0};
            if (trial >= {1'b0, d_reg}) begin
                r_next = trial - {1'b0, d_reg};
                q_next = {q_reg[NW-2:0], 1'b1};
            end else begin
                r_next = trial;
                q_next = {q_reg[NW-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CW'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg <= cnt_next;
        end
        n_reg <= n_next;
        q_reg <= q_next;
        r_reg <= r_next;
        d_reg <= d_next;
        neg_reg <= neg_next;
        zero_reg <= zero_next;
    end

    assign done = done_reg;
    assign quot = zero_reg ? '0 : from_mag(neg_reg, PW'(q_reg));

endmodule

>>> rtl/kpv_checker.sv
`include "assert_macros.svh"

module kpv_checker
    import kpv_pkg::*;
(
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [95:0] m_tdata
);

    `ASSERT_CLK(a_hold, aclk, aresetn, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata), "output beat dropped")
    `ASSERT_CLK(a_one_item, aclk, aresetn, s_tvalid && s_tready |=> !s_tready, "second beat taken during work")
    `ASSERT_CLK(a_no_early, aclk, aresetn, s_tvalid && s_tready |=> ##1 $stable(m_tvalid) || !m_tvalid, "result before work")
    `ASSERT_ALWAYS(a_rst, aclk, !aresetn |=> !m_tvalid && !s_tready, "not idle after reset")

endmodule

bind kalman_pos_vel_filter kpv_checker u_kpv_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

>>> tb/tb.sv
`timescale 1ns / 100ps

module tb;
    import kpv_pkg::*;

    typedef struct {
        logic        upd;
        logic [15:0] dt;
        logic [31:0] accel;
        logic [31:0] meas;
    } kf_req_t;

    typedef struct {
        logic [31:0] pos;
        logic [31:0] vel;
        logic [31:0] p00;
    } kf_est_t;

    logic        aclk;
    logic        aresetn;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [2:0]  cfg_index;
    logic [31:0] cfg_data;
    logic        s_tvalid;
    logic        s_tready;
    logic        s_tuser;
    logic [87:0] s_tdata;
    logic        m_tvalid;
    logic        m_tready;
    logic [95:0] m_tdata;

    kalman_pos_vel_filter dut (.*);

    always begin
        aclk = 1'b0;
        #2;
        aclk = 1'b1;
        #2;
    end

    // predictor state
    longint  est_pos, est_vel;
    longint  cov [4];
    longint  nz_pp, nz_pv, nz_vp, nz_vv, nz_r;

    kf_req_t pend_q [$];
    kf_est_t est_q [$];
    int      src_idle, snk_idle;
    int      errors, n_pred, n_upd, n_res, stall_cnt;
    logic    hold_go, hold_seen;
    int      hold_left;

    function automatic longint sat32(longint v);
        if (v > 64'sd2147483647) return 64'sd2147483647;
        if (v < -64'sd2147483648) return -64'sd2147483648;
        return v;
    endfunction

    function automatic longint sx(logic [31:0] v);
        return longint'($signed(v));
    endfunction

    function automatic longint qmul(longint a, longint b);
        longint p, m;
        p = a * b;
        m = (p < 0) ? -p : p;
        m = m >> 16;
        return sat32((p < 0) ? -m : m);
    endfunction

    function automatic longint qdiv(longint n, longint d);
        longint un, ud, q;
        if (d == 0) return 0;
        un = (n < 0) ? -n : n;
        ud = (d < 0) ? -d : d;
        q = (un << 16) / ud;
        return sat32(((n < 0) != (d < 0)) ? -q : q);
    endfunction

    function automatic kf_est_t kf_step(kf_req_t r);
        kf_est_t e;
        longint dt, adt, half, a01, p00, p01, p10, p11, s, k0, k1, y;
        p00 = cov[0]; p01 = cov[1]; p10 = cov[2]; p11 = cov[3];
        if (!r.upd) begin
            dt = longint'(r.dt);
            adt = qmul(sx(r.accel), dt);
            half = qmul(adt, dt) / 2;
            est_pos = sat32(sat32(est_pos + qmul(est_vel, dt)) + half);
            est_vel = sat32(est_vel + adt);
            a01 = sat32(p01 + qmul(dt, p11));
            cov[0] = sat32(sat32(sat32(p00 + qmul(dt, p10)) + qmul(a01, dt)) + nz_pp);
            cov[1] = sat32(a01 + nz_pv);
            cov[2] = sat32(sat32(p10 + qmul(p11, dt)) + nz_vp);
            cov[3] = sat32(p11 + nz_vv);
        end else begin
            s = sat32(p00 + nz_r);
            k0 = qdiv(p00, s);
            k1 = qdiv(p10, s);
            y = sat32(sx(r.meas) - est_pos);
            est_pos = sat32(est_pos + qmul(k0, y));
            est_vel = sat32(est_vel + qmul(k1, y));
            cov[0] = sat32(p00 - qmul(k0, p00));
            cov[1] = sat32(p01 - qmul(k0, p01));
            cov[2] = sat32(p10 - qmul(k1, p00));
            cov[3] = sat32(p11 - qmul(k1, p01));
        end
        e.pos = est_pos[31:0];
        e.vel = est_vel[31:0];
        e.p00 = cov[0][31:0];
        return e;
    endfunction

    // input driver
    always @(posedge aclk) begin
        kf_req_t r;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else if (!s_tvalid || s_tready) begin
            if (pend_q.size() > 0 && $urandom_range(99) >= src_idle) begin
                r = pend_q.pop_front();
                s_tvalid <= 1'b1;
                s_tuser <= r.upd;
                s_tdata <= {8'd0, r.meas, r.accel, r.dt};
                est_q.push_back(kf_step(r));
                if (r.upd) n_upd++;
                else n_pred++;
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // output monitor
    always @(posedge aclk) begin
        kf_est_t e;
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                n_res++;
                if (est_q.size() == 0) begin
                    $error("unexpected output beat %h", m_tdata);
                    errors++;
                end else begin
                    e = est_q.pop_front();
                    if (m_tdata[31:0] !== e.pos) begin
                        $error("pos_est exp %h got %h", e.pos, m_tdata[31:0]);
                        errors++;
                    end
                    if (m_tdata[63:32] !== e.vel) begin
                        $error("vel_est exp %h got %h", e.vel, m_tdata[63:32]);
                        errors++;
                    end
                    if (m_tdata[95:64] !== e.p00) begin
                        $error("pos_variance exp %h got %h", e.p00, m_tdata[95:64]);
                        errors++;
                    end
                end
            end
            if (hold_go && !hold_seen) begin
                hold_seen <= 1'b1;
                hold_left <= 700;
                m_tready <= 1'b0;
            end else if (hold_left > 0) begin
                hold_left <= hold_left - 1;
                m_tready <= 1'b0;
            end else begin
                m_tready <= ($urandom_range(99) >= snk_idle);
            end
        end
    end

    // watchdog
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)
            || !aresetn)
            stall_cnt <= 0;
        else if (pend_q.size() > 0 || est_q.size() > 0 || s_tvalid || cfg_valid) begin
            stall_cnt <= stall_cnt + 1;
            if (stall_cnt >= 4000) begin
                $display("watchdog: no progress, %0d beats outstanding", est_q.size());
                $display("Simulation FAILED");
                $finish;
            end
        end
    end

    task automatic cfg_write(logic [2:0] idx, logic [31:0] val);
        @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            REG_QPP: nz_pp = longint'(val[30:0]);
            REG_QPV: nz_pv = sx(val);
            REG_QVP: nz_vp = sx(val);
            REG_QVV: nz_vv = longint'(val[30:0]);
            REG_R:   nz_r = longint'(val[30:0]);
            default: ;
        endcase
    endtask

    task automatic cfg_all(logic [31:0] pp, logic [31:0] pv, logic [31:0] vp,
                           logic [31:0] vv, logic [31:0] rr);
        cfg_write(REG_QPP, pp);
        cfg_write(REG_QPV, pv);
        cfg_write(REG_QVP, vp);
        cfg_write(REG_QVV, vv);
        cfg_write(REG_R, rr);
    endtask

    task automatic drain();
        while (pend_q.size() > 0 || s_tvalid || est_q.size() > 0) @(posedge aclk);
        repeat (200) @(posedge aclk);
    endtask

    task automatic add_req(logic upd, logic [15:0] dt, logic [31:0] ac, logic [31:0] ms);
        kf_req_t r;
        r.upd = upd; r.dt = dt; r.accel = ac; r.meas = ms;
        pend_q.push_back(r);
    endtask

    task automatic add_random(int n);
        for (int i = 0; i < n; i++) begin
            if ($urandom_range(3) == 0)
                add_req(1'($urandom_range(1)), 16'($urandom), $urandom, $urandom);
            else
                add_req(1'($urandom_range(1)), 16'($urandom_range(6554)),
                        32'($signed($urandom_range(2000000)) - 1000000),
                        32'($signed($urandom_range(20000000)) - 10000000));
        end
    endtask

    initial begin
        aresetn = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        s_tvalid = 1'b0;
        s_tuser = 1'b0;
        s_tdata = '0;
        m_tready = 1'b0;
        hold_go = 1'b0;
        hold_seen = 1'b0;
        hold_left = 0;
        errors = 0; n_pred = 0; n_upd = 0; n_res = 0; stall_cnt = 0;
        src_idle = 0; snk_idle = 0;
        est_pos = 0; est_vel = 0;
        cov[0] = 65536; cov[1] = 0; cov[2] = 0; cov[3] = 65536;
        nz_pp = 0; nz_pv = 0; nz_vp = 0; nz_vv = 0; nz_r = 3277;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        repeat (3) @(posedge aclk);

        // directed, reset settings
        add_req(1'b0, 16'd0, 32'h0000_0000, 32'h0);
        add_req(1'b0, 16'hFFFF, 32'h7FFF_FFFF, 32'h0);
        add_req(1'b1, 16'h0, 32'h0, 32'h7FFF_FFFF);
        add_req(1'b0, 16'hFFFF, 32'h8000_0000, 32'hFFFF_FFFF);
        add_req(1'b1, 16'hFFFF, 32'hFFFF_FFFF, 32'h8000_0000);
        add_req(1'b0, 16'h8000, 32'h0001_0000, 32'h0);
        add_req(1'b1, 16'h0, 32'h0, 32'h0010_0000);
        add_req(1'b0, 16'h0001, 32'hFFFF_0000, 32'h0);
        drain();
        // zero innovation variance: R = 0 drives P00 to zero, then S is zero
        cfg_all(32'h0, 32'h0, 32'h0, 32'h0, 32'h0);
        cfg_write(3'd5, 32'hFFFF_FFFF);
        cfg_write(3'd7, 32'h1234_5678);
        add_req(1'b1, 16'h0, 32'h0, 32'h0003_0000);
        add_req(1'b1, 16'h0, 32'h0, 32'h0005_0000);
        add_req(1'b1, 16'h0, 32'h0, 32'hFFF0_0000);
        add_req(1'b0, 16'h1000, 32'h0002_0000, 32'h0);
        drain();
        // extreme noise, negative cross terms
        cfg_all(32'hFFFF_FFFF, 32'h8000_0000, 32'h8000_0000, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        add_req(1'b0, 16'hFFFF, 32'h7FFF_FFFF, 32'h0);
        add_req(1'b1, 16'h0, 32'h0, 32'h7FFF_FFFF);
        add_req(1'b0, 16'h0100, 32'h8000_0000, 32'h0);
        add_req(1'b1, 16'h0, 32'h0, 32'h8000_0000);
        drain();
        cfg_all(32'h0, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h0, 32'h0);
        add_req(1'b0, 16'h0400, 32'h0, 32'h0);
        add_req(1'b1, 16'h0, 32'h0, 32'h0001_0000);
        add_req(1'b1, 16'h0, 32'h0, 32'hFFFF_0000);
        drain();

        src_idle = 34; snk_idle = 56;
        cfg_all(32'd100, 32'd10, -32'sd10, 32'd200, 32'd3277);
        add_random(210);
        drain();

        src_idle = 56; snk_idle = 34;
        cfg_all($urandom, $urandom, $urandom, $urandom, $urandom);
        add_random(210);
        drain();

        src_idle = 0; snk_idle = 0;
        cfg_all(32'd655, 32'hFFFF_FF00, 32'd256, 32'd1311, 32'd65536);
        add_random(210);
        hold_go = 1'b1;
        drain();

        $display("covered %0d predict and %0d update beats, %0d results checked",
                 n_pred, n_upd, n_res);
        $display("settings: reset, zero and full-scale noise, random, idle and stall mixes");
        if (errors == 0 && est_q.size() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

>>> files.f
+incdir+rtl
rtl/kpv_pkg.sv
rtl/kpv_div.sv
rtl/kalman_pos_vel_filter.sv
rtl/kpv_checker.sv
tb/tb.sv
